[rtl/nested_page_table_engine_defines.svh]
// ----------------------------------------------------------------------------
// nested page table engine assertion macros
// property forms for npte_ctrl, which checks its own control logic
// ----------------------------------------------------------------------------
`ifndef NESTED_PAGE_TABLE_ENGINE_DEFINES_SVH
`define NESTED_PAGE_TABLE_ENGINE_DEFINES_SVH

// condition holds in the same cycle as the trigger
`define NPTE_ASSERT_SAME(label, trig, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error(msg);

// condition holds in the cycle after the trigger
`define NPTE_ASSERT_NEXT(label, trig, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error(msg);

`endif

[rtl/npte_pkg.sv]
// ----------------------------------------------------------------------------
// npte_pkg
// types, constants and command/status bundles of the nested page table engine
// ----------------------------------------------------------------------------
`default_nettype none

package npte_pkg;

    // table store geometry
    localparam int TABLE_PAGES       = 16;
    localparam int ENTRIES_PER_TABLE = 512;
    localparam int SLOT_W            = $clog2(ENTRIES_PER_TABLE);
    localparam int PAGE_W            = $clog2(TABLE_PAGES);
    localparam int ADDR_W            = PAGE_W + SLOT_W;
    localparam int STORE_DEPTH       = TABLE_PAGES * ENTRIES_PER_TABLE;
    localparam int FREE_W            = $clog2(TABLE_PAGES + 1);
    localparam int ENTRY_W           = 64;

    // fixed field widths
    localparam int GPA_W   = 48;
    localparam int HPA_W   = 52;
    localparam int FRAME_W = 40;
    localparam int COUNT_W = 5;

    // table levels
    localparam logic [1:0] LVL_PML4 = 2'd3;
    localparam logic [1:0] LVL_PDPT = 2'd2;
    localparam logic [1:0] LVL_PD   = 2'd1;
    localparam logic [1:0] LVL_PT   = 2'd0;

    // entry bit positions
    localparam int BIT_P  = 0;
    localparam int BIT_PS = 7;

    typedef enum logic [1:0] {
        OP_MAP   = 2'd0,
        OP_UNMAP = 2'd1,
        OP_QUERY = 2'd2,
        OP_CLEAR = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_INVALID  = 2'd1,
        ST_MAPPED   = 2'd2,
        ST_NO_PAGES = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        W_ZERO = 2'd0,
        W_PTR  = 2'd1,
        W_LEAF = 2'd2
    } wsel_t;

    typedef enum logic [1:0] {
        A_WALK = 2'd0,
        A_PAGE = 2'd1,
        A_ALL  = 2'd2
    } amode_t;

    typedef struct packed {
        op_t                operation;
        logic [GPA_W-1:0]   guest_addr;
        logic [HPA_W-1:0]   host_addr;
        logic               large_page;
        logic [2:0]         protection;
    } in_item_t;

    typedef struct packed {
        status_t            status;
        logic               hit;
        logic [HPA_W-1:0]   translated_addr;
        logic [COUNT_W-1:0] pages_in_use;
    } out_item_t;

    // controller to datapath
    typedef struct packed {
        logic    load;
        logic    we;
        wsel_t   wsel;
        amode_t  addr_mode;
        logic    sweep_rst;
        logic    sweep_inc;
        logic    descend_rel;
        logic    descend_new;
        logic    pool_clr;
        logic    res_we;
        status_t res_status;
        logic    res_hit;
        logic    res_large;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        op_t        op;
        logic       big_page;
        logic [1:0] level;
        logic       arg_bad;
        logic       e_p;
        logic       e_ps;
        logic       stale;
        logic       pool_full;
        logic       page_last;
        logic       all_last;
    } stat_t;

endpackage

`default_nettype wire

[rtl/npte_ram.sv]
// ----------------------------------------------------------------------------
// npte_ram
// single port ram with registered read
// ----------------------------------------------------------------------------
`default_nettype none

module npte_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 8192
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

`default_nettype wire

[rtl/npte_datapath.sv]
// ----------------------------------------------------------------------------
// npte_datapath
// item registers, walk pointer, page allocator, table store and result
// ----------------------------------------------------------------------------
`default_nettype none

module npte_datapath (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [npte_pkg::HPA_W-1:0]        cfg_wdata,
    input  wire npte_pkg::in_item_t                in_item,
    input  wire npte_pkg::cmd_t                    cmd,
    output npte_pkg::stat_t                        stat,
    output npte_pkg::out_item_t                    out_item
);

    localparam int SW = npte_pkg::SLOT_W;
    localparam int PW = npte_pkg::PAGE_W;
    localparam int AW = npte_pkg::ADDR_W;
    localparam int FW = npte_pkg::FREE_W;
    localparam int RW = npte_pkg::FRAME_W;
    localparam int HW = npte_pkg::HPA_W;
    localparam int CW = npte_pkg::COUNT_W;
    localparam int EW = npte_pkg::ENTRY_W;

    npte_pkg::in_item_t     item_reg;
    logic [HW-1:0]          table_base_reg;
    logic [1:0]             level_reg, level_next;
    logic [PW-1:0]          page_reg, page_next;
    logic [FW-1:0]          free_reg, free_next;
    logic [AW-1:0]          sweep_reg, sweep_next;
    npte_pkg::status_t      status_reg;
    logic                   hit_reg;
    logic [HW-1:0]          addr_reg;

    logic [SW-1:0]          slot;
    logic [AW-1:0]          ram_addr;
    logic [EW-1:0]          ram_wdata;
    logic [EW-1:0]          rdata;
    logic [RW-1:0]          rel;
    logic [RW-1:0]          ptr_frame;
    logic [EW-1:0]          ptr_entry;
    logic [EW-1:0]          leaf_entry;
    logic [HW-1:0]          xlate;

    // table index of the current level
    always_comb
    begin
        case (level_reg)
            npte_pkg::LVL_PML4: slot = item_reg.guest_addr[47:39];
            npte_pkg::LVL_PDPT: slot = item_reg.guest_addr[38:30];
            npte_pkg::LVL_PD:   slot = item_reg.guest_addr[29:21];
            default:            slot = item_reg.guest_addr[20:12];
        endcase
    end

    // store address select
    always_comb
    begin
        case (cmd.addr_mode)
            npte_pkg::A_PAGE: ram_addr = {page_reg, sweep_reg[SW-1:0]};
            npte_pkg::A_ALL:  ram_addr = sweep_reg;
            default:          ram_addr = {page_reg, slot};
        endcase
    end

    // pointer and leaf entries
    assign ptr_frame  = table_base_reg[HW-1:12] + RW'(free_reg);
    assign ptr_entry  = {12'h000, ptr_frame, 12'h007};
    assign leaf_entry = {~item_reg.protection[2], 11'h000, item_reg.host_addr[HW-1:12],
                         4'h0, item_reg.large_page, 4'h0, 1'b1,
                         item_reg.protection[1], 1'b1};

    always_comb
    begin
        case (cmd.wsel)
            npte_pkg::W_PTR:  ram_wdata = ptr_entry;
            npte_pkg::W_LEAF: ram_wdata = leaf_entry;
            default:          ram_wdata = '0;
        endcase
    end

    npte_ram #(
        .WIDTH (EW),
        .DEPTH (npte_pkg::STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (cmd.we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (rdata)
    );

    // page number of a read pointer entry
    assign rel = rdata[HW-1:12] - table_base_reg[HW-1:12];

    // translation of a hit
    assign xlate = cmd.res_large ? {rdata[HW-1:21], item_reg.guest_addr[20:0]}
                                 : {rdata[HW-1:12], item_reg.guest_addr[11:0]};

    // walk pointer, allocator and sweep counter
    always_comb
    begin
        level_next = level_reg;
        page_next  = page_reg;
        free_next  = free_reg;
        sweep_next = sweep_reg;
        if (cmd.load)
        begin
            level_next = npte_pkg::LVL_PML4;
            page_next  = '0;
        end
        if (cmd.descend_rel)
        begin
            level_next = level_reg - 2'd1;
            page_next  = rel[PW-1:0];
        end
        if (cmd.descend_new)
        begin
            level_next = level_reg - 2'd1;
            page_next  = free_reg[PW-1:0];
            free_next  = free_reg + FW'(1);
        end
        if (cmd.pool_clr)
        begin
            free_next = FW'(1);
        end
        if (cmd.sweep_rst)
        begin
            sweep_next = '0;
        end
        else if (cmd.sweep_inc)
        begin
            sweep_next = sweep_reg + AW'(1);
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            table_base_reg <= '0;
            level_reg      <= npte_pkg::LVL_PML4;
            page_reg       <= '0;
            free_reg       <= FW'(1);
            sweep_reg      <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                table_base_reg <= cfg_wdata;
            end
            level_reg <= level_next;
            page_reg  <= page_next;
            free_reg  <= free_next;
            sweep_reg <= sweep_next;
        end
    end

    // item and result registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg   <= in_item;
            status_reg <= npte_pkg::ST_OK;
            hit_reg    <= 1'b0;
            addr_reg   <= '0;
        end
        else if (cmd.res_we)
        begin
            status_reg <= cmd.res_status;
            hit_reg    <= cmd.res_hit;
            addr_reg   <= cmd.res_hit ? xlate : '0;
        end
    end

    // status to the controller
    always_comb
    begin
        stat.op        = item_reg.operation;
        stat.big_page  = item_reg.large_page;
        stat.level     = level_reg;
        stat.e_p       = rdata[npte_pkg::BIT_P];
        stat.e_ps      = rdata[npte_pkg::BIT_PS];
        stat.stale     = |rel[RW-1:PW];
        stat.pool_full = free_reg >= FW'(npte_pkg::TABLE_PAGES);
        stat.page_last = &sweep_reg[SW-1:0];
        stat.all_last  = &sweep_reg;
        if (item_reg.operation == npte_pkg::OP_MAP)
        begin
            stat.arg_bad = (|(item_reg.guest_addr[11:0] | item_reg.host_addr[11:0]))
                        || (item_reg.protection == 3'd0)
                        || (item_reg.large_page
                            && (|(item_reg.guest_addr[20:12] | item_reg.host_addr[20:12])));
        end
        else
        begin
            stat.arg_bad = (|item_reg.guest_addr[11:0])
                        || (item_reg.large_page && (|item_reg.guest_addr[20:12]));
        end
    end

    // result item
    assign out_item.status          = status_reg;
    assign out_item.hit             = hit_reg;
    assign out_item.translated_addr = addr_reg;
    assign out_item.pages_in_use    = CW'(free_reg);

endmodule

`default_nettype wire

[rtl/npte_ctrl.sv]
// ----------------------------------------------------------------------------
// npte_ctrl
// sequencer for table walks, allocation, leaf writes and clearing sweeps
// ----------------------------------------------------------------------------
`default_nettype none
`include "nested_page_table_engine_defines.svh"

module npte_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_stall,
    output logic                 out_valid,
    input  wire logic            out_stall,
    input  wire npte_pkg::stat_t stat,
    output npte_pkg::cmd_t       cmd
);

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_START,
        S_READ,
        S_EVAL,
        S_CLR_PAGE,
        S_CLR_ALL,
        S_DONE
    } state_t;

    state_t state_reg, state_next;
    logic   gap;

    // entry that ends a walk without a lower table
    assign gap = stat.e_ps || !stat.e_p || stat.stale;

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        cmd.wsel       = npte_pkg::W_ZERO;
        cmd.addr_mode  = npte_pkg::A_WALK;
        cmd.res_status = npte_pkg::ST_OK;
        case (state_reg)
            // clearing pass after reset
            S_INIT:
            begin
                cmd.addr_mode = npte_pkg::A_ALL;
                cmd.we        = 1'b1;
                cmd.sweep_inc = 1'b1;
                if (stat.all_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_START;
                end
            end
            // argument check for map and unmap, and dispatch
            S_START:
            begin
                case (stat.op)
                    npte_pkg::OP_CLEAR:
                    begin
                        cmd.sweep_rst = 1'b1;
                        cmd.pool_clr  = 1'b1;
                        state_next    = S_CLR_ALL;
                    end
                    npte_pkg::OP_QUERY:
                    begin
                        state_next = S_READ;
                    end
                    default:
                    begin
                        if (stat.arg_bad)
                        begin
                            cmd.res_we     = 1'b1;
                            cmd.res_status = npte_pkg::ST_INVALID;
                            state_next     = S_DONE;
                        end
                        else
                        begin
                            state_next = S_READ;
                        end
                    end
                endcase
            end
            S_READ:
            begin
                state_next = S_EVAL;
            end
            // one table entry is on the read port
            S_EVAL:
            begin
                state_next = S_DONE;
                cmd.res_we = 1'b1;
                if (stat.level[1])
                begin
                    // upper levels
                    if (stat.op == npte_pkg::OP_MAP)
                    begin
                        if (stat.e_ps || (stat.e_p && stat.stale)
                            || (!stat.e_p && stat.pool_full))
                        begin
                            cmd.res_status = npte_pkg::ST_NO_PAGES;
                        end
                        else if (!stat.e_p)
                        begin
                            cmd.res_we      = 1'b0;
                            cmd.we          = 1'b1;
                            cmd.wsel        = npte_pkg::W_PTR;
                            cmd.descend_new = 1'b1;
                            state_next      = S_READ;
                        end
                        else
                        begin
                            cmd.res_we      = 1'b0;
                            cmd.descend_rel = 1'b1;
                            state_next      = S_READ;
                        end
                    end
                    else if (!gap)
                    begin
                        cmd.res_we      = 1'b0;
                        cmd.descend_rel = 1'b1;
                        state_next      = S_READ;
                    end
                end
                else if (stat.level == npte_pkg::LVL_PD)
                begin
                    case (stat.op)
                        npte_pkg::OP_QUERY:
                        begin
                            if (stat.e_p && stat.e_ps)
                            begin
                                cmd.res_hit   = 1'b1;
                                cmd.res_large = 1'b1;
                            end
                            else if (!gap)
                            begin
                                cmd.res_we      = 1'b0;
                                cmd.descend_rel = 1'b1;
                                state_next      = S_READ;
                            end
                        end
                        npte_pkg::OP_UNMAP:
                        begin
                            if (stat.e_p && stat.e_ps)
                            begin
                                if (stat.big_page)
                                begin
                                    cmd.we = 1'b1;
                                end
                                else
                                begin
                                    cmd.res_status = npte_pkg::ST_INVALID;
                                end
                            end
                            else if (!gap)
                            begin
                                cmd.res_we      = 1'b0;
                                cmd.descend_rel = 1'b1;
                                if (stat.big_page)
                                begin
                                    cmd.sweep_rst = 1'b1;
                                    state_next    = S_CLR_PAGE;
                                end
                                else
                                begin
                                    state_next = S_READ;
                                end
                            end
                        end
                        default:
                        begin
                            if (stat.big_page)
                            begin
                                if (stat.e_p)
                                begin
                                    cmd.res_status = npte_pkg::ST_MAPPED;
                                end
                                else
                                begin
                                    cmd.we   = 1'b1;
                                    cmd.wsel = npte_pkg::W_LEAF;
                                end
                            end
                            else if (stat.e_p && stat.e_ps)
                            begin
                                cmd.res_status = npte_pkg::ST_MAPPED;
                            end
                            else if (stat.e_ps || (stat.e_p && stat.stale)
                                     || (!stat.e_p && stat.pool_full))
                            begin
                                cmd.res_status = npte_pkg::ST_NO_PAGES;
                            end
                            else if (!stat.e_p)
                            begin
                                cmd.res_we      = 1'b0;
                                cmd.we          = 1'b1;
                                cmd.wsel        = npte_pkg::W_PTR;
                                cmd.descend_new = 1'b1;
                                state_next      = S_READ;
                            end
                            else
                            begin
                                cmd.res_we      = 1'b0;
                                cmd.descend_rel = 1'b1;
                                state_next      = S_READ;
                            end
                        end
                    endcase
                end
                else
                begin
                    // page table level
                    case (stat.op)
                        npte_pkg::OP_QUERY:
                        begin
                            cmd.res_hit = stat.e_p;
                        end
                        npte_pkg::OP_UNMAP:
                        begin
                            cmd.we = 1'b1;
                        end
                        default:
                        begin
                            if (stat.e_p)
                            begin
                                cmd.res_status = npte_pkg::ST_MAPPED;
                            end
                            else
                            begin
                                cmd.we   = 1'b1;
                                cmd.wsel = npte_pkg::W_LEAF;
                            end
                        end
                    endcase
                end
            end
            // wipe the page table under a 2 MiB unmap
            S_CLR_PAGE:
            begin
                cmd.addr_mode = npte_pkg::A_PAGE;
                cmd.we        = 1'b1;
                cmd.sweep_inc = 1'b1;
                if (stat.page_last)
                begin
                    state_next = S_DONE;
                end
            end
            // wipe the whole store
            S_CLR_ALL:
            begin
                cmd.addr_mode = npte_pkg::A_ALL;
                cmd.we        = 1'b1;
                cmd.sweep_inc = 1'b1;
                if (stat.all_last)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_stall)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = (state_reg == S_DONE);

    // checks
    `NPTE_ASSERT_SAME(a_alloc_room, cmd.descend_new, !stat.pool_full,
        "table page allocated with the pool exhausted")
    `NPTE_ASSERT_SAME(a_descend_level, cmd.descend_rel || cmd.descend_new,
        stat.level != npte_pkg::LVL_PT, "walk descends below the page table level")
    `NPTE_ASSERT_SAME(a_idle_quiet, !in_stall, !cmd.we && !cmd.res_we,
        "store or result written while idle")
    `NPTE_ASSERT_NEXT(a_result_once, out_valid && !out_stall, !out_valid,
        "result offered twice")

endmodule

`default_nettype wire

[rtl/nested_page_table_engine.sv]
// ----------------------------------------------------------------------------
// nested_page_table_engine
// four-level nested page table kept in an on-chip store, with map, unmap,
// query and clear
// ----------------------------------------------------------------------------
// One item is handled at a time. After acceptance an item passes a start
// state, then a store read and an evaluation for each table level walked,
// and then a done state that offers its result until out_stall is low; the
// block then returns to idle before it takes the next item.
// A 2 MiB unmap over a page table sweeps that table's 512 entries, one per
// cycle, and a clear sweeps the whole store of 8192 entries. After reset the
// block runs a clearing pass over all 8192 entries before it takes its first
// item. Write table_base only while no item is in flight.
`default_nettype none

module nested_page_table_engine (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_we,
    input  wire logic [npte_pkg::HPA_W-1:0] cfg_wdata,
    input  wire logic                       in_valid,
    output logic                            in_stall,
    input  wire npte_pkg::in_item_t         in_item,
    output logic                            out_valid,
    input  wire logic                       out_stall,
    output npte_pkg::out_item_t             out_item
);

    npte_pkg::cmd_t  cmd;
    npte_pkg::stat_t stat;

    // sequencer
    npte_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    // store and walk datapath
    npte_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_item   (in_item),
        .cmd       (cmd),
        .stat      (stat),
        .out_item  (out_item)
    );

endmodule

`default_nettype wire
